>>> rtl/core/bule_pkg.sv
// ----------------------------------------------------------------------------
// bule_pkg
// Shared types and codes for the bounded unique list engine.
// ----------------------------------------------------------------------------
package bule_pkg;

  localparam int unsigned ReqW    = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HitW    = 3;
  localparam int unsigned OrderW  = 2;
  localparam int unsigned CountW  = 4;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_FILTER = 2'd2,
    REQ_ORDER  = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [OrderW-1:0] {
    ORD_UNSORTED   = 2'd0,
    ORD_ASCENDING  = 2'd1,
    ORD_DESCENDING = 2'd2
  } order_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/bounded_unique_list_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_unique_list_engine_top
// Bounded list of signed 32-bit values: unique insert, search, parity filter,
// order check. One result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis (tuser = request kind, tdata = value, keep_even).
//   Each request yields one result on m_axis (tuser = status, tdata = hit
//   index, order code, entry count).
//   One request is in work at a time. After acceptance the entry walk reads
//   one entry per cycle from the single read port of the entry memory, whose
//   read data is registered; then the request commits in its commit state,
//   and the result is valid on the edge after the commit.
//   The result sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, the following request stops in
//   its commit cycle until the output register is free.
//   Reset empties the list (fill count 0) and drops any pending result.
// ----------------------------------------------------------------------------
module bounded_unique_list_engine_top #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [31:0] value, [32] keep_even
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [2:0] hit_index, [4:3] order_code,
                                     // [8:5] entry_count
  output logic [1:0]  m_axis_tuser   // [1:0] status
);
  import bule_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         dp_status;
  logic [StatusW-1:0] status;
  logic [HitW-1:0]    hit_index;
  logic [OrderW-1:0]  order_code;
  logic [CountW-1:0]  entry_count;

  bule_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  bule_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .req_type_i        (s_axis_tuser),
    .value_i           (s_axis_tdata[31:0]),
    .keep_even_i       (s_axis_tdata[32]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_status_o      (status),
    .out_hit_index_o   (hit_index),
    .out_order_code_o  (order_code),
    .out_entry_count_o (entry_count)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {7'd0, entry_count, order_code, hit_index};

endmodule

>>> rtl/core/bule_ctrl.sv
// ----------------------------------------------------------------------------
// bule_ctrl
// Request sequencer: accept, walk the stored entries, commit the result.
// ----------------------------------------------------------------------------
module bule_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  bule_pkg::dp_status_t  status_i,
  output bule_pkg::ctrl_cmd_t   cmd_o
);
  import bule_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (status_i.walk_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == S_WALK)
    else $error("start did not enter walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_IDLE)
    else $error("finish did not return to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.step, cmd_o.finish}))
    else $error("overlapping commands");

endmodule

>>> rtl/core/bule_dp.sv
// ----------------------------------------------------------------------------
// bule_dp
// Entry memory, walk pointers, match/filter/order evaluation, result register.
// ----------------------------------------------------------------------------
module bule_dp #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bule_pkg::ctrl_cmd_t               cmd_i,
  output bule_pkg::dp_status_t              status_o,
  input  logic [bule_pkg::ReqW-1:0]         req_type_i,
  input  logic signed [bule_pkg::ValueW-1:0] value_i,
  input  logic                              keep_even_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bule_pkg::StatusW-1:0]      out_status_o,
  output logic [bule_pkg::HitW-1:0]         out_hit_index_o,
  output logic [bule_pkg::OrderW-1:0]       out_order_code_o,
  output logic [bule_pkg::CountW-1:0]       out_entry_count_o
);
  import bule_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  logic signed [ValueW-1:0] mem [DEPTH];
  logic signed [ValueW-1:0] rdata_q;
  logic                     we;
  logic [IdxW-1:0]          waddr;
  logic signed [ValueW-1:0] wdata;

  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]          ev_idx_q, ev_idx_d;
  logic                     rvalid_q, rvalid_d;
  logic [CntW-1:0]          kept_q, kept_d;
  logic                     found_q, found_d;
  logic [IdxW-1:0]          hit_q, hit_d;
  logic                     asc_q, asc_d;
  logic                     des_q, des_d;
  logic signed [ValueW-1:0] prev_q, prev_d;
  req_e                     req_q;
  logic signed [ValueW-1:0] value_q;
  logic                     keep_even_q;

  logic                     out_valid_q;
  logic [StatusW-1:0]       res_status;
  logic [IdxW-1:0]          res_hit;
  logic [OrderW-1:0]        res_order;
  logic [CntW-1:0]          res_count;
  logic [StatusW-1:0]       out_status_q;
  logic [HitW-1:0]          out_hit_q;
  logic [OrderW-1:0]        out_order_q;
  logic [CountW-1:0]        out_count_q;

  logic                     list_full;
  logic                     rd_more;
  logic                     eq_hit;
  logic                     keep_it;

  assign list_full = (count_q == CntW'(DEPTH));
  assign rd_more   = (rd_idx_q != count_q);
  assign eq_hit    = (rdata_q == value_q);
  assign keep_it   = rdata_q[0] ^ keep_even_q;

  assign status_o.walk_done = !rd_more && !rvalid_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[rd_idx_q[IdxW-1:0]];
  end

  // walk and evaluation
  always_comb begin
    rd_idx_d = rd_idx_q;
    ev_idx_d = ev_idx_q;
    rvalid_d = 1'b0;
    kept_d   = kept_q;
    found_d  = found_q;
    hit_d    = hit_q;
    asc_d    = asc_q;
    des_d    = des_q;
    prev_d   = prev_q;
    we       = 1'b0;
    waddr    = kept_q[IdxW-1:0];
    wdata    = rdata_q;
    if (cmd_i.start) begin
      rd_idx_d = '0;
      kept_d   = '0;
      found_d  = 1'b0;
      hit_d    = '0;
      asc_d    = 1'b1;
      des_d    = 1'b1;
    end else if (cmd_i.step) begin
      if (rd_more) begin
        rd_idx_d = rd_idx_q + 1'b1;
        ev_idx_d = rd_idx_q[IdxW-1:0];
        rvalid_d = 1'b1;
      end
      if (rvalid_q) begin
        case (req_q)
          REQ_INSERT: begin
            if (eq_hit && !found_q) begin
              found_d = 1'b1;
              hit_d   = ev_idx_q;
            end
          end
          REQ_SEARCH: begin
            if (eq_hit) begin
              found_d = 1'b1;
              hit_d   = ev_idx_q;
            end
          end
          REQ_FILTER: begin
            if (keep_it) begin
              we     = 1'b1;
              kept_d = kept_q + 1'b1;
            end
          end
          default: begin
            if (ev_idx_q != '0) begin
              if (rdata_q < prev_q) asc_d = 1'b0;
              if (prev_q < rdata_q) des_d = 1'b0;
            end
            prev_d = rdata_q;
          end
        endcase
      end
    end else if (cmd_i.finish) begin
      if (req_q == REQ_INSERT && !list_full && !found_q) begin
        we    = 1'b1;
        waddr = count_q[IdxW-1:0];
        wdata = value_q;
      end
    end
  end

  // result of the finished request
  always_comb begin
    res_status = ST_OK;
    res_hit    = '0;
    res_order  = ORD_UNSORTED;
    res_count  = count_q;
    case (req_q)
      REQ_INSERT: begin
        if (list_full) begin
          res_status = ST_FULL;
        end else if (found_q) begin
          res_status = ST_DUPLICATE;
          res_hit    = hit_q;
        end else begin
          res_count = count_q + 1'b1;
        end
      end
      REQ_SEARCH: begin
        if (found_q) begin
          res_hit = hit_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      REQ_FILTER: begin
        res_count = kept_q;
      end
      default: begin
        if (asc_q) begin
          res_order = ORD_ASCENDING;
        end else if (des_q) begin
          res_order = ORD_DESCENDING;
        end
      end
    endcase
  end

  assign count_d = cmd_i.finish ? res_count : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      ev_idx_q    <= '0;
      rvalid_q    <= 1'b0;
      kept_q      <= '0;
      found_q     <= 1'b0;
      hit_q       <= '0;
      asc_q       <= 1'b1;
      des_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      ev_idx_q <= ev_idx_d;
      rvalid_q <= rvalid_d;
      kept_q   <= kept_d;
      found_q  <= found_d;
      hit_q    <= hit_d;
      asc_q    <= asc_d;
      des_q    <= des_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    if (cmd_i.start) begin
      req_q       <= req_e'(req_type_i);
      value_q     <= value_i;
      keep_even_q <= keep_even_i;
    end
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_hit_q    <= HitW'(res_hit);
      out_order_q  <= res_order;
      out_count_q  <= CountW'(res_count);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_hit_index_o   = out_hit_q;
  assign out_order_code_o  = out_order_q;
  assign out_entry_count_o = out_count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> rd_idx_q <= count_q)
    else $error("read pointer beyond fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && rvalid_q) |-> kept_q <= CntW'(ev_idx_q))
    else $error("filter write overtakes read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("result not presented after finish");

endmodule

>>> verif/tb_bounded_unique_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_unique_list_engine_top
// Self-checking bench for the bounded unique list engine. A directed table
// covers the empty list, the signed extremes, duplicates, the full list,
// search hits at index 0, both filter modes and all order codes. Random
// requests follow, with trend phases that build sorted lists. Every result
// is checked field by field against its table row or the in-bench predictor,
// with random stalls on both streams, one long output stall, one drain pause.
// ----------------------------------------------------------------------------
module tb_bounded_unique_list_engine_top;
  import bule_pkg::*;

  localparam int unsigned DEPTH       = 8;
  localparam int unsigned RAND_ITEMS  = 750;
  localparam int unsigned QUIET_ITEMS = 150;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_e        status;
    logic [2:0]     hit;
    order_e         order;
    logic [3:0]     count;
  } list_result_t;

  typedef struct packed {
    req_e           req;
    logic [31:0]    value;
    logic           keep_even;
    bit             typed;
    list_result_t   want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [31:0] value, [32] keep_even
  logic [1:0]  s_axis_tuser;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [2:0] hit_index, [4:3] order_code, [8:5] entry_count
  logic [1:0]  m_axis_tuser;   // [1:0] status

  logic [31:0]  list_mem [DEPTH];
  int           list_fill;
  list_result_t pending_q [$];
  dir_row_t     dir_tab [$];
  int           err_cnt;
  int           result_cnt;
  int           cycle_cnt;
  bit           idle_en;
  bit           long_hold;

  bounded_unique_list_engine_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // list predictor: updates the list copy and returns the expected result
  function automatic list_result_t apply_request(req_e r, logic [31:0] v, logic keep_even);
    list_result_t res;
    int           i;
    int           kept;
    bit           found;
    bit           asc;
    bit           des;
    res.status = ST_OK;
    res.hit    = '0;
    res.order  = ORD_UNSORTED;
    found      = 1'b0;
    case (r)
      REQ_INSERT: begin
        if (list_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = 0; i < list_fill && !found; i++) begin
            if (list_mem[i] == v) begin
              found   = 1'b1;
              res.hit = i[2:0];
            end
          end
          if (found) begin
            res.status = ST_DUPLICATE;
          end else begin
            list_mem[list_fill] = v;
            list_fill++;
          end
        end
      end
      REQ_SEARCH: begin
        for (i = 0; i < list_fill; i++) begin
          if (list_mem[i] == v) begin
            found   = 1'b1;
            res.hit = i[2:0];
          end
        end
        if (!found) begin
          res.status = ST_NOT_FOUND;
        end
      end
      REQ_FILTER: begin
        kept = 0;
        for (i = 0; i < list_fill; i++) begin
          if ((list_mem[i][0] == 1'b0) == keep_even) begin
            list_mem[kept] = list_mem[i];
            kept++;
          end
        end
        for (i = kept; i < DEPTH; i++) begin
          list_mem[i] = '0;
        end
        list_fill = kept;
      end
      default: begin
        asc = 1'b1;
        des = 1'b1;
        for (i = 1; i < list_fill; i++) begin
          if ($signed(list_mem[i]) < $signed(list_mem[i-1])) asc = 1'b0;
          if ($signed(list_mem[i-1]) < $signed(list_mem[i])) des = 1'b0;
        end
        if (asc) begin
          res.order = ORD_ASCENDING;
        end else if (des) begin
          res.order = ORD_DESCENDING;
        end
      end
    endcase
    res.count = list_fill[3:0];
    return res;
  endfunction

  function automatic dir_row_t mk_row(req_e r, logic [31:0] v, logic ke, bit typed,
                                      status_e s, logic [2:0] h, order_e o, logic [3:0] c);
    dir_row_t row;
    row.req         = r;
    row.value       = v;
    row.keep_even   = ke;
    row.typed       = typed;
    row.want.status = s;
    row.want.hit    = h;
    row.want.order  = o;
    row.want.count  = c;
    return row;
  endfunction

  // trend 1 climbs from the last entry, trend 2 falls from it
  function automatic logic [31:0] pick_value(int trend);
    int          sel;
    logic [31:0] base;
    sel = $urandom_range(0, 9);
    if (trend != 0 && list_fill > 0 && sel < 6) begin
      base = list_mem[list_fill-1];
      if (trend == 1) return base + $urandom_range(0, 4);
      return base - $urandom_range(0, 4);
    end
    if (list_fill > 0 && sel < 3) return list_mem[$urandom_range(0, list_fill - 1)];
    if (sel < 6) return 32'($urandom_range(0, 15)) - 32'd8;
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", result_cnt, what, got, want);
    err_cnt++;
  endtask

  task automatic send_request(input req_e r, input logic [31:0] v, input logic ke,
                              input bit typed, input list_result_t want);
    list_result_t pred;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r;
    s_axis_tdata  <= {7'b0, ke, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = apply_request(r, v, ke);
    pending_q.push_back(typed ? want : pred);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
  endtask

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        flag_mismatch("result with no request outstanding", m_axis_tuser, -1);
      end else begin
        list_result_t want;
        want = pending_q.pop_front();
        if (m_axis_tuser   != want.status) flag_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[2:0] != want.hit) flag_mismatch("hit_index", m_axis_tdata[2:0], want.hit);
        if (m_axis_tdata[4:3] != want.order) begin
          flag_mismatch("order_code", m_axis_tdata[4:3], want.order);
        end
        if (m_axis_tdata[8:5] != want.count) begin
          flag_mismatch("entry_count", m_axis_tdata[8:5], want.count);
        end
      end
      result_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    list_result_t none;
    int           k;
    int           trend;
    int           sel;
    req_e         r;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_INSERT;
    rst_ni        = 1'b0;
    err_cnt       = 0;
    result_cnt    = 0;
    cycle_cnt     = 0;
    idle_en       = 1'b1;
    long_hold     = 1'b0;
    list_fill     = 0;
    trend         = 0;
    none          = '0;
    for (k = 0; k < DEPTH; k++) list_mem[k] = '0;

    // empty list
    dir_tab.push_back(mk_row(REQ_ORDER,  32'd0, 1'b0, 1, ST_OK, 3'd0, ORD_ASCENDING, 4'd0));
    dir_tab.push_back(mk_row(REQ_SEARCH, 32'd0, 1'b0, 1, ST_NOT_FOUND, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_FILTER, 32'd0, 1'b1, 1, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    // signed extremes, duplicate, hit at index 0
    dir_tab.push_back(mk_row(REQ_INSERT, 32'h8000_0000, 1'b0, 1, ST_OK, 3'd0, ORD_UNSORTED, 4'd1));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'h7FFF_FFFF, 1'b1, 1, ST_OK, 3'd0, ORD_UNSORTED, 4'd2));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'h8000_0000, 1'b0, 1, ST_DUPLICATE, 3'd0,
                             ORD_UNSORTED, 4'd2));
    dir_tab.push_back(mk_row(REQ_SEARCH, 32'h8000_0000, 1'b0, 1, ST_OK, 3'd0, ORD_UNSORTED, 4'd2));
    dir_tab.push_back(mk_row(REQ_ORDER,  32'd0, 1'b0, 1, ST_OK, 3'd0, ORD_ASCENDING, 4'd2));
    // fill up to DEPTH
    dir_tab.push_back(mk_row(REQ_INSERT, 32'hFFFF_FFFF, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'hFFFF_FFFD, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'd4, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'd6, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'd5, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'd2, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    // full list wins over duplicate
    dir_tab.push_back(mk_row(REQ_INSERT, 32'd9, 1'b0, 1, ST_FULL, 3'd0, ORD_UNSORTED, 4'd8));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'h7FFF_FFFF, 1'b0, 1, ST_FULL, 3'd0, ORD_UNSORTED, 4'd8));
    dir_tab.push_back(mk_row(REQ_SEARCH, 32'd6, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_SEARCH, 32'd123, 1'b0, 1, ST_NOT_FOUND, 3'd0, ORD_UNSORTED, 4'd8));
    dir_tab.push_back(mk_row(REQ_ORDER,  32'd0, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    // keep odd (negative odd included), then keep even on an all-odd list
    dir_tab.push_back(mk_row(REQ_FILTER, 32'd0, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_SEARCH, 32'hFFFF_FFFD, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_FILTER, 32'd0, 1'b1, 1, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    // descending list
    dir_tab.push_back(mk_row(REQ_INSERT, 32'd10, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'd5, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_INSERT, 32'hFFFF_FFFB, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));
    dir_tab.push_back(mk_row(REQ_ORDER,  32'd0, 1'b0, 0, ST_OK, 3'd0, ORD_UNSORTED, 4'd0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].req, dir_tab[i].value, dir_tab[i].keep_even,
                   dir_tab[i].typed, dir_tab[i].want);
    end

    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 30 == 0) trend = $urandom_range(0, 2);
      if (k % 60 == 0) idle_en = ($urandom_range(0, 2) != 0);
      if (k >= RAND_ITEMS - QUIET_ITEMS) idle_en = 1'b0;
      if (k == 200) long_hold = 1'b1;
      if (k == 400) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      sel = $urandom_range(0, 19);
      if (sel < 9) begin
        r = REQ_INSERT;
      end else if (sel < 14) begin
        r = REQ_SEARCH;
      end else if (sel < 17) begin
        r = REQ_ORDER;
      end else begin
        r = REQ_FILTER;
      end
      send_request(r, pick_value(trend), 1'($urandom_range(0, 1)), 0, none);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bule_pkg.sv
rtl/core/bule_ctrl.sv
rtl/core/bule_dp.sv
rtl/core/bounded_unique_list_engine_top.sv
verif/tb_bounded_unique_list_engine_top.sv
